### design/integer_literal_parser_top_defines.svh
// Assertion macros shared by the checker of the integer literal parser.
`ifndef INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILP_CHECK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ilp_pkg.sv
// Types, codes and constants shared by the integer literal parser modules.
package ilp_pkg;

	localparam int unsigned ACCUM_W = 64;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	// Register index decoded from the word address.
	localparam logic REG_TARGET_FORMAT = 1'b0;

	// Error codes.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EMPTY      = 3'd1;
	localparam logic [2:0] ERR_NO_DIGITS  = 3'd2;
	localparam logic [2:0] ERR_BAD_CHAR   = 3'd3;
	localparam logic [2:0] ERR_DIGIT_BASE = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd5;
	localparam logic [2:0] ERR_ONLY_SEP   = 3'd6;
	localparam logic [2:0] ERR_RANGE      = 3'd7;

	// Target formats.
	localparam logic [2:0] FMT_U64 = 3'd0;
	localparam logic [2:0] FMT_U32 = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_U8  = 3'd3;
	localparam logic [2:0] FMT_I64 = 3'd4;
	localparam logic [2:0] FMT_I32 = 3'd5;
	localparam logic [2:0] FMT_I16 = 3'd6;
	localparam logic [2:0] FMT_I8  = 3'd7;

	// Character codes.
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_PLUS       = 8'h2b;
	localparam logic [7:0] CH_MINUS      = 8'h2d;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_F    = 8'h66;
	localparam logic [7:0] CH_LOWER_B    = 8'h62;
	localparam logic [7:0] CH_LOWER_X    = 8'h78;
	localparam logic [7:0] CASE_BIT      = 8'h20;
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_SIGN  = 2'd1,
		PH_ZERO  = 2'd2,
		PH_BODY  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [ACCUM_W-1:0] accum;
		radix_t             radix;
		logic               neg;
		phase_t             phase;
		logic               saw_digit;
		logic               saw_body;
		logic [2:0]         err;
	} ilp_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic [ACCUM_W-1:0] value_bits;
		logic               ok;
		logic [2:0]         error_code;
	} res_item_t;

	localparam ilp_state_t STATE_CLEAR = '{
		accum: '0, radix: RADIX_DEC, neg: 1'b0, phase: PH_START,
		saw_digit: 1'b0, saw_body: 1'b0, err: ERR_NONE
	};

endpackage

### design/ilp_step.sv
// Per-character parse state and its update for one character item.
module ilp_step
	import ilp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       proc,
	input  char_item_t item,
	output ilp_state_t snap
);

	ilp_state_t state_q;
	ilp_state_t state_d;

	function automatic ilp_state_t body_char(ilp_state_t s, logic [7:0] c);
		ilp_state_t  r;
		logic [7:0]  lower;
		logic [3:0]  d;
		logic        is_dec;
		logic        is_hex_letter;
		logic [ACCUM_W+3:0] dec_sum;
		r = s;
		lower = c | CASE_BIT;
		is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
		is_hex_letter = (s.radix == RADIX_HEX) && (lower >= CH_LOWER_A) &&
			(lower <= CH_LOWER_F);
		d = is_dec ? c[3:0] : (lower[3:0] + HEX_LETTER_OFS);
		dec_sum = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1) +
			{{ACCUM_W{1'b0}}, d};
		r.saw_body = 1'b1;
		if (c == CH_UNDERSCORE) begin
			r.saw_body = 1'b1;
		end else if (!is_dec && !is_hex_letter) begin
			r.err = ERR_BAD_CHAR;
		end else begin
			case (s.radix)
				RADIX_HEX: begin
					if (s.accum[ACCUM_W-1 -: 4] != 4'd0) begin
						r.err = ERR_OVERFLOW;
					end else begin
						r.accum = {s.accum[ACCUM_W-5:0], d};
						r.saw_digit = 1'b1;
					end
				end
				RADIX_BIN: begin
					if (d > 4'd1) begin
						r.err = ERR_DIGIT_BASE;
					end else if (s.accum[ACCUM_W-1]) begin
						r.err = ERR_OVERFLOW;
					end else begin
						r.accum = {s.accum[ACCUM_W-2:0], d[0]};
						r.saw_digit = 1'b1;
					end
				end
				default: begin
					if (dec_sum[ACCUM_W+3:ACCUM_W] != 4'd0) begin
						r.err = ERR_OVERFLOW;
					end else begin
						r.accum = dec_sum[ACCUM_W-1:0];
						r.saw_digit = 1'b1;
					end
				end
			endcase
		end
		return r;
	endfunction

	// A character where a prefix may begin: a lone zero is held pending.
	function automatic ilp_state_t prefix_pos(ilp_state_t s, logic [7:0] c);
		ilp_state_t r;
		r = s;
		if (c == CH_ZERO) begin
			r.phase = PH_ZERO;
			r.saw_body = 1'b1;
			r.saw_digit = 1'b1;
			r.accum = '0;
		end else begin
			r.phase = PH_BODY;
			r = body_char(r, c);
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0] lower;
		lower = item.ch | CASE_BIT;
		state_d = state_q;
		if (item.has_char && (state_q.err == ERR_NONE)) begin
			case (state_q.phase)
				PH_START: begin
					if (item.ch == CH_MINUS) begin
						state_d.neg = 1'b1;
						state_d.phase = PH_SIGN;
					end else if (item.ch == CH_PLUS) begin
						state_d.phase = PH_SIGN;
					end else begin
						state_d = prefix_pos(state_q, item.ch);
					end
				end
				PH_SIGN: begin
					state_d = prefix_pos(state_q, item.ch);
				end
				PH_ZERO: begin
					state_d.phase = PH_BODY;
					if ((lower == CH_LOWER_X) || (lower == CH_LOWER_B)) begin
						state_d.radix = (lower == CH_LOWER_X) ? RADIX_HEX : RADIX_BIN;
						state_d.saw_body = 1'b0;
						state_d.saw_digit = 1'b0;
						state_d.accum = '0;
					end else begin
						state_d = body_char(state_d, item.ch);
					end
				end
				default: begin
					state_d = body_char(state_q, item.ch);
				end
			endcase
		end
	end

	assign snap = state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (proc) begin
			state_q <= item.last ? STATE_CLEAR : state_d;
		end
	end

endmodule

### design/ilp_finish.sv
// Final error selection and range check against the target format.
module ilp_finish
	import ilp_pkg::*;
(
	input  ilp_state_t snap,
	input  logic [2:0] fmt,
	output res_item_t  res
);

	logic [ACCUM_W-1:0] mask;
	logic               fits;
	logic               at_lim;
	logic [2:0]         range_err;
	logic [2:0]         err;

	// Mask of the magnitudes that fit, per format.
	always_comb begin
		case (fmt)
			FMT_U64: mask = {ACCUM_W{1'b1}};
			FMT_U32: mask = {{(ACCUM_W-32){1'b0}}, {32{1'b1}}};
			FMT_U16: mask = {{(ACCUM_W-16){1'b0}}, {16{1'b1}}};
			FMT_U8:  mask = {{(ACCUM_W-8){1'b0}}, {8{1'b1}}};
			FMT_I64: mask = {1'b0, {(ACCUM_W-1){1'b1}}};
			FMT_I32: mask = {{(ACCUM_W-31){1'b0}}, {31{1'b1}}};
			FMT_I16: mask = {{(ACCUM_W-15){1'b0}}, {15{1'b1}}};
			default: mask = {{(ACCUM_W-7){1'b0}}, {7{1'b1}}};
		endcase
	end

	always_comb begin
		fits = (snap.accum & ~mask) == '0;
		at_lim = snap.accum == (mask + {{(ACCUM_W-1){1'b0}}, 1'b1});
		if (!fmt[2]) begin
			range_err = (snap.neg || !fits) ? ERR_RANGE : ERR_NONE;
		end else if (snap.neg) begin
			range_err = (fits || at_lim) ? ERR_NONE : ERR_RANGE;
		end else begin
			range_err = fits ? ERR_NONE : ERR_RANGE;
		end

		if (snap.err != ERR_NONE) begin
			err = snap.err;
		end else if (snap.phase == PH_START) begin
			err = ERR_EMPTY;
		end else if (!snap.saw_body) begin
			err = ERR_NO_DIGITS;
		end else if (!snap.saw_digit) begin
			err = ERR_ONLY_SEP;
		end else begin
			err = range_err;
		end

		res.ok = err == ERR_NONE;
		res.error_code = err;
		if (err != ERR_NONE) begin
			res.value_bits = '0;
		end else if (snap.neg) begin
			res.value_bits = '0 - snap.accum;
		end else begin
			res.value_bits = snap.accum;
		end
	end

endmodule

### design/integer_literal_parser_top.sv
// Integer literal parser: takes one character item per cycle unless char_stall is raised (an input
// register, the character step that updates the parse state, a snapshot register for a finished
// literal, the range check and an output register). The sustained rate is one character item per
// clock cycle while the input is not stalled; the combinational update of the 64-bit accumulator
// (a times-ten shift-add and carry check) sets it. The result for an item marked last moves from
// the input register to the snapshot register and then to the output register.
// Each stage moves on when the next one is empty or emptying, so characters keep being
// taken while a result waits. target_format is written over the APB port at byte 0.
module integer_literal_parser_top
	import ilp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  char_item_t        char_item,
	output logic              res_valid,
	input  logic              res_stall,
	output res_item_t         res_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [2:0]  fmt_q;
	logic        v_s1;
	char_item_t  item_s1;
	logic        v_s2;
	ilp_state_t  snap_s2;
	ilp_state_t  snap;
	res_item_t   res;
	logic        res_valid_q;
	res_item_t   res_item_q;
	logic        ready_out;
	logic        ready_s2;
	logic        ready_s1;
	logic        proc_s1;
	logic        reg_hit;

	// Configuration register.
	assign pready = 1'b1;
	assign reg_hit = paddr[ADDR_W-1:2] == REG_TARGET_FORMAT;
	assign prdata = reg_hit ? {{(DATA_W-3){1'b0}}, fmt_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_U64;
		end else if (psel && penable && pwrite && reg_hit) begin
			fmt_q <= pwdata[2:0];
		end
	end

	// Flow control: a character without last needs no room downstream.
	assign ready_out = !res_valid_q || !res_stall;
	assign ready_s2 = !v_s2 || ready_out;
	assign proc_s1 = v_s1 && (!item_s1.last || ready_s2);
	assign ready_s1 = !v_s1 || proc_s1;
	assign char_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= char_valid;
			end
			if (ready_s2) begin
				v_s2 <= proc_s1 && item_s1.last;
			end
			if (ready_out) begin
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && char_valid) begin
			item_s1 <= char_item;
		end
		if (ready_s2 && proc_s1 && item_s1.last) begin
			snap_s2 <= snap;
		end
		if (ready_out && v_s2) begin
			res_item_q <= res;
		end
	end

	ilp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc_s1),
		.item   (item_s1),
		.snap   (snap)
	);

	ilp_finish u_finish (
		.snap (snap_s2),
		.fmt  (fmt_q),
		.res  (res)
	);

	assign res_valid = res_valid_q;
	assign res_item = res_item_q;

endmodule

### design/ilp_checker.sv
// Port-level checks of the integer literal parser, bound to the top level.
`include "integer_literal_parser_top_defines.svh"

module ilp_checker
	import ilp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_stall,
	input char_item_t        char_item,
	input logic              res_valid,
	input logic              res_stall,
	input res_item_t         res_item,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready
);

	// An empty output stage always lets characters in.
	`ILP_CHECK_SAME(a_no_stall_when_empty, !res_valid, !char_stall, "input stalled with empty output")

	`ILP_CHECK_SAME(a_ok_matches_code, res_valid, res_item.ok == (res_item.error_code == ERR_NONE), "ok flag disagrees with error code")

	`ILP_CHECK_SAME(a_error_value_zero, res_valid && !res_item.ok, res_item.value_bits == '0, "failed result carries a value")

	`ILP_CHECK_NEXT(a_result_held, res_valid && res_stall, res_valid && $stable(res_item), "stalled result changed")

endmodule

bind integer_literal_parser_top ilp_checker u_ilp_checker (.*);

### verif/ilp_literal_checker.sv
// Checker that predicts the result of every literal sent to the parser and compares it.
module ilp_literal_checker
	import ilp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	input  logic              char_stall,
	input  char_item_t        char_item,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_item_t         res_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                outstanding,
	output int                literals_done
);

	ilp_state_t parse;
	logic [2:0] target_fmt;
	res_item_t  literal_results_q[$];
	int         mismatches;
	int         literals;

	task automatic take_body_char(input logic [7:0] c);
		logic [4:0]  base;
		logic [7:0]  lower;
		logic [4:0]  digit;
		logic        is_digit;
		logic [67:0] next_acc;
		if (parse.radix == RADIX_HEX) begin
			base = 5'd16;
		end else if (parse.radix == RADIX_BIN) begin
			base = 5'd2;
		end else begin
			base = 5'd10;
		end
		lower = c | CASE_BIT;
		digit = '0;
		is_digit = 1'b1;
		parse.saw_body = 1'b1;
		if (c != CH_UNDERSCORE) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				digit = 5'(c - CH_ZERO);
			end else if (parse.radix == RADIX_HEX && lower >= CH_LOWER_A &&
					lower <= CH_LOWER_F) begin
				digit = 5'(lower - CH_LOWER_A) + 5'd10;
			end else begin
				parse.err = ERR_BAD_CHAR;
				is_digit = 1'b0;
			end
			if (is_digit) begin
				// The carry out of the 64-bit magnitude shows up in the top four bits.
				next_acc = 68'(parse.accum) * 68'(base) + 68'(digit);
				if (digit >= base) begin
					parse.err = ERR_DIGIT_BASE;
				end else if (next_acc[67:64] != '0) begin
					parse.err = ERR_OVERFLOW;
				end else begin
					parse.accum = next_acc[63:0];
					parse.saw_digit = 1'b1;
				end
			end
		end
	endtask

	task automatic take_prefix_char(input logic [7:0] c);
		if (c == CH_ZERO) begin
			parse.phase = PH_ZERO;
			parse.saw_body = 1'b1;
			parse.saw_digit = 1'b1;
			parse.accum = '0;
		end else begin
			parse.phase = PH_BODY;
			take_body_char(c);
		end
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [7:0] lower;
		lower = c | CASE_BIT;
		case (parse.phase)
			PH_START: begin
				if (c == CH_MINUS) begin
					parse.neg = 1'b1;
					parse.phase = PH_SIGN;
				end else if (c == CH_PLUS) begin
					parse.phase = PH_SIGN;
				end else begin
					take_prefix_char(c);
				end
			end
			PH_SIGN: begin
				take_prefix_char(c);
			end
			PH_ZERO: begin
				// A lone zero followed by x or b turns into a radix prefix.
				parse.phase = PH_BODY;
				if (lower == CH_LOWER_X || lower == CH_LOWER_B) begin
					if (lower == CH_LOWER_X) begin
						parse.radix = RADIX_HEX;
					end else begin
						parse.radix = RADIX_BIN;
					end
					parse.saw_body = 1'b0;
					parse.saw_digit = 1'b0;
					parse.accum = '0;
				end else begin
					take_body_char(c);
				end
			end
			default: begin
				take_body_char(c);
			end
		endcase
	endtask

	function automatic res_item_t literal_result(input ilp_state_t s, input logic [2:0] fmt);
		res_item_t   r;
		logic [2:0]  code;
		logic [63:0] val;
		logic [63:0] lim;
		int          bits;
		val = '0;
		case (fmt)
			FMT_U64, FMT_I64: bits = 64;
			FMT_U32, FMT_I32: bits = 32;
			FMT_U16, FMT_I16: bits = 16;
			default:          bits = 8;
		endcase
		if (s.err != ERR_NONE) begin
			code = s.err;
		end else if (s.phase == PH_START) begin
			code = ERR_EMPTY;
		end else if (!s.saw_body) begin
			code = ERR_NO_DIGITS;
		end else if (!s.saw_digit) begin
			code = ERR_ONLY_SEP;
		end else if (fmt < FMT_I64) begin
			if (s.neg || (bits < 64 && (s.accum >> bits) != '0)) begin
				code = ERR_RANGE;
			end else begin
				code = ERR_NONE;
				val = s.accum;
			end
		end else begin
			lim = 64'd1 << (bits - 1);
			if (s.neg ? (s.accum > lim) : (s.accum > lim - 64'd1)) begin
				code = ERR_RANGE;
			end else begin
				code = ERR_NONE;
				val = s.neg ? (64'd0 - s.accum) : s.accum;
			end
		end
		r.value_bits = val;
		r.ok = (code == ERR_NONE);
		r.error_code = code;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			parse = STATE_CLEAR;
			target_fmt = FMT_U64;
			literal_results_q.delete();
			mismatches = 0;
			literals = 0;
			fail_count <= 0;
			outstanding <= 0;
			literals_done <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[ADDR_W-1:2] == REG_TARGET_FORMAT) begin
				target_fmt = pwdata[2:0];
			end
			if (res_valid && !res_stall) begin
				if (literal_results_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: expected nothing, got value %h ok %b code %0d",
						$time, res_item.value_bits, res_item.ok, res_item.error_code);
				end else begin
					want = literal_results_q.pop_front();
					literals++;
					if (res_item.value_bits !== want.value_bits || res_item.ok !== want.ok ||
							res_item.error_code !== want.error_code) begin
						mismatches++;
						$display("%0t: mismatch: expected value %h ok %b code %0d, got value %h ok %b code %0d",
							$time, want.value_bits, want.ok, want.error_code,
							res_item.value_bits, res_item.ok, res_item.error_code);
					end
				end
			end
			if (char_valid && !char_stall) begin
				if (char_item.has_char && parse.err == ERR_NONE) begin
					take_char(char_item.ch);
				end
				if (char_item.last) begin
					literal_results_q.push_back(literal_result(parse, target_fmt));
					parse = STATE_CLEAR;
				end
			end
			fail_count <= mismatches;
			outstanding <= literal_results_q.size();
			literals_done <= literals;
		end
	end

endmodule

### verif/tb_integer_literal_parser_top.sv
// Testbench top for the integer literal parser: stimulus, idling, configuration and verdict.
module tb_integer_literal_parser_top
	import ilp_pkg::*;
;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int BLOCK_ITEMS  = 55;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              char_valid = 1'b0;
	logic              char_stall;
	char_item_t        char_item = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_item_t         res_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int outstanding;
	int literals_done;

	int send_idle_pct = 17;
	int recv_idle_pct = 63;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int items_sent = 0;

	logic [7:0] lit_chars[$];

	logic [2:0] fmt_order [0:7] = '{FMT_U64, FMT_I8, FMT_U8, FMT_I64,
		FMT_U32, FMT_I16, FMT_U16, FMT_I32};

	integer_literal_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ilp_literal_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .outstanding(outstanding), .literals_done(literals_done)
	);

	always #2 clk = ~clk;

	// Output side: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (res_valid && !res_stall) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_char(input logic [7:0] c, input logic has, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{ch: c, has_char: has, last: fin};
		@(posedge clk);
		while (char_stall) begin
			@(posedge clk);
		end
		if (has || fin) begin
			items_sent++;
		end
	endtask

	// Sends the characters held in lit_chars, with now and then an item carrying none.
	task automatic send_literal(input logic end_without_char);
		int i;
		for (i = 0; i < lit_chars.size(); i++) begin
			if ($urandom_range(19) == 0) begin
				send_char(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_char(lit_chars[i], 1'b1, (i == lit_chars.size() - 1) && !end_without_char);
		end
		if (end_without_char || lit_chars.size() == 0) begin
			send_char(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	task automatic send_text(input string s);
		int i;
		lit_chars.delete();
		for (i = 0; i < s.len(); i++) begin
			lit_chars.push_back(s[i]);
		end
		send_literal(1'b0);
	endtask

	task automatic wait_drained;
		char_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_target_format(input logic [2:0] fmt);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TARGET_FORMAT, 2'b00};
		pwdata <= {29'($urandom), fmt};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(input logic [63:0] d);
		logic [7:0] c;
		if (d < 10) begin
			c = CH_ZERO + 8'(d);
		end else begin
			c = CH_LOWER_A + 8'(d) - 8'd10;
			if ($urandom_range(1)) begin
				c = c & ~CASE_BIT;
			end
		end
		return c;
	endfunction

	// Mostly well-formed literals, some with values near the type limits; the rest are
	// corrupted or cut short, or plain noise.
	task automatic build_random_literal;
		int          kind;
		int          base;
		int          n;
		int          pos;
		int          b;
		radix_t      r;
		logic [63:0] v;
		logic [7:0]  c;
		logic [7:0]  digs [0:63];
		kind = $urandom_range(99);
		lit_chars.delete();
		if (kind < 80) begin
			case ($urandom_range(3))
				0: lit_chars.push_back(CH_MINUS);
				1: lit_chars.push_back(CH_PLUS);
				default: ;
			endcase
			case ($urandom_range(2))
				0: r = RADIX_DEC;
				1: r = RADIX_HEX;
				default: r = RADIX_BIN;
			endcase
			base = (r == RADIX_HEX) ? 16 : ((r == RADIX_BIN) ? 2 : 10);
			if (r != RADIX_DEC) begin
				lit_chars.push_back(CH_ZERO);
				c = (r == RADIX_HEX) ? CH_LOWER_X : CH_LOWER_B;
				lit_chars.push_back($urandom_range(1) ? c : (c & ~CASE_BIT));
			end
			if ($urandom_range(9) == 0) begin
				lit_chars.push_back(CH_UNDERSCORE);
			end
			if ($urandom_range(4) == 0) begin
				// Raw digit string, long enough at times to carry past 64 bits.
				n = $urandom_range((r == RADIX_BIN) ? 66 : ((r == RADIX_HEX) ? 18 : 22), 1);
				repeat (n) begin
					lit_chars.push_back(digit_char($urandom_range(base - 1)));
					if ($urandom_range(9) == 0) begin
						lit_chars.push_back(CH_UNDERSCORE);
					end
				end
			end else begin
				case ($urandom_range(3))
					0: v = 64'($urandom_range(300));
					1: begin
						case ($urandom_range(4))
							0: b = 8;
							1: b = 16;
							2: b = 32;
							3: b = 63;
							default: b = 64;
						endcase
						v = ((b == 64) ? 64'd0 : (64'd1 << b)) + 64'($urandom_range(6)) - 64'd3;
					end
					2: v = {$urandom, $urandom} >> $urandom_range(63);
					default: v = {$urandom, $urandom};
				endcase
				n = 0;
				do begin
					digs[n] = digit_char(v % 64'(base));
					v = v / 64'(base);
					n++;
				end while (v != 0);
				while (n > 0) begin
					n--;
					lit_chars.push_back(digs[n]);
					if (n > 0 && $urandom_range(9) == 0) begin
						lit_chars.push_back(CH_UNDERSCORE);
					end
				end
			end
			if (kind >= 65) begin
				pos = $urandom_range(lit_chars.size() - 1);
				if ($urandom_range(1)) begin
					lit_chars[pos] = 8'($urandom_range(255));
				end else begin
					while (lit_chars.size() > pos + 1) begin
						void'(lit_chars.pop_back());
					end
				end
			end
		end else begin
			n = $urandom_range(6, 1);
			repeat (n) begin
				case ($urandom_range(5))
					0: c = CH_PLUS;
					1: c = CH_MINUS;
					2: c = CH_UNDERSCORE;
					3: c = CH_ZERO;
					4: c = CH_LOWER_X;
					default: c = 8'($urandom_range(255));
				endcase
				lit_chars.push_back(c);
			end
		end
	endtask

	initial begin
		int         blk_start;
		logic [2:0] fmt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed literals under the reset result type, unsigned 64-bit, then two under signed 8-bit.
		lit_chars.delete();
		send_literal(1'b1);
		send_text("-0");
		send_text("0b2");
		lit_chars.delete();
		lit_chars.push_back(8'h00);
		lit_chars.push_back(8'hff);
		send_literal(1'b0);
		send_char(CH_PLUS, 1'b1, 1'b0);
		send_char(8'h55, 1'b0, 1'b0);
		send_char(8'haa, 1'b0, 1'b1);
		send_text("_");
		send_text("0x10000000000000000");
		wait_drained();
		write_target_format(FMT_I8);
		send_text("-128");
		send_text("128");
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct <= 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct <= 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				fmt = (ph * 4 + blk < 8) ? fmt_order[ph * 4 + blk] :
					fmt_order[$urandom_range(7)];
				write_target_format(fmt);
				if (ph == 0 && blk == 1) begin
					hold_requests <= hold_requests + 1;
				end
				blk_start = items_sent;
				while (items_sent - blk_start < BLOCK_ITEMS) begin
					build_random_literal();
					send_literal($urandom_range(99) < 12);
				end
				wait_drained();
			end
		end

		$display("Run covered %0d character items and %0d literal results, all result types,",
			items_sent, literals_done);
		$display("three idling mixes, a long output hold-off and directed edge cases.");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
